// ----- hw/rtl/lrs_pkg.sv -----
package lrs_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TOUCH  = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // Field widths fixed by the item format
    localparam int OP_W   = 2;
    localparam int WAY_W  = 3;
    localparam int RANK_W = 3;
    localparam int CNT_W  = 4;

    // Per-cycle move command broadcast to every cell
    typedef struct packed {
        logic push_all;      // every cell takes its upper neighbor (insert)
        logic push_to_pos;   // cells at or above pos take upper neighbor (touch)
        logic pull_from_pos; // cells at or below pos take lower neighbor (remove)
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/lrs_cell.sv -----
module lrs_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 3
) (
    input  logic                      clk,
    input  lrs_pkg::cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]          pos,
    input  logic [lrs_pkg::CNT_W-1:0] count,
    input  logic [lrs_pkg::WAY_W-1:0] req_way,
    input  logic [lrs_pkg::WAY_W-1:0] prev_way,
    input  logic [lrs_pkg::WAY_W-1:0] next_way,
    output logic [lrs_pkg::WAY_W-1:0] way,
    output logic [lrs_pkg::WAY_W-1:0] way_after,
    output logic                      hit
);
    import lrs_pkg::*;

    logic [WAY_W-1:0] way_reg;
    logic [WAY_W-1:0] way_next;
    logic             listed;
    logic             at_or_above;
    logic             at_or_below;

    // Only cells inside the fill level hold a listed way
    assign listed      = (CELL_INDEX < count);
    assign hit         = listed && (way_reg == req_way);
    assign at_or_above = (CELL_INDEX <= pos);
    assign at_or_below = (CELL_INDEX >= pos);

    // Move select: from the front neighbor, from the back neighbor, or hold
    always_comb
    begin
        way_next = way_reg;
        if (ctrl.push_all || (ctrl.push_to_pos && at_or_above))
        begin
            way_next = prev_way;
        end
        else if (ctrl.pull_from_pos && at_or_below)
        begin
            way_next = next_way;
        end
    end

    always_ff @(posedge clk)
    begin
        way_reg <= way_next;
    end

    assign way       = way_reg;
    assign way_after = way_next;

endmodule

// ----- hw/rtl/lru_recency_stack_core.sv -----
// A request's result is registered at the edge that accepts it and is on the ports,
// marked by done, during the following cycle.
// Throughput: one request per cycle; busy stays low, and the cell row updates at the edge that accepts the request.
// Reset (rst_n, async, active low) empties the stack and clears done;
// cell contents are not reset. The receiver cannot stall results.
module lru_recency_stack_core #(
    parameter int WAYS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lrs_pkg::OP_W-1:0]   operation,
    input  logic [lrs_pkg::WAY_W-1:0]  way,
    output logic                       done,
    output logic                       found,
    output logic [lrs_pkg::RANK_W-1:0] rank,
    output logic [lrs_pkg::WAY_W-1:0]  lru_way,
    output logic [lrs_pkg::CNT_W-1:0]  entry_count,
    output logic                       error
);
    import lrs_pkg::*;

    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAY_W-1:0]  cell_way   [WAYS];
    logic [WAY_W-1:0]  cell_after [WAYS];
    logic [WAY_W-1:0]  cell_prev  [WAYS];
    logic [WAY_W-1:0]  cell_next  [WAYS];
    logic [WAYS-1:0]   hit_vec;

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              hit;
    logic              full;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W+RANK_W-1:0] pos_ext;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              err_now;
    logic [WAY_W-1:0]  lru_now;

    logic              done_reg;
    logic              found_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [WAY_W-1:0]  lru_reg;
    logic              error_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Row of cells, neighbor links
    for (genvar i = 0; i < WAYS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_front
            assign cell_prev[i] = way;
        end
        else
        begin : g_mid
            assign cell_prev[i] = cell_way[i-1];
        end
        if (i == WAYS - 1)
        begin : g_back
            assign cell_next[i] = cell_way[i];
        end
        else
        begin : g_inner
            assign cell_next[i] = cell_way[i+1];
        end

        lrs_cell #(
            .CELL_INDEX (i),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .pos       (pos),
            .count     (count_reg),
            .req_way   (way),
            .prev_way  (cell_prev[i]),
            .next_way  (cell_next[i]),
            .way       (cell_way[i]),
            .way_after (cell_after[i]),
            .hit       (hit_vec[i])
        );
    end

    // Position of the matching cell; listed ways are distinct, so at most one hits
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (hit_vec[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign hit     = |hit_vec;
    assign full    = (count_reg >= WAYS);
    assign pos_ext = {{RANK_W{1'b0}}, pos};

    // Decode request into cell moves and the new fill level
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        err_now    = 1'b0;
        if (accept)
        begin
            unique case (operation)
                OP_INSERT:
                begin
                    if (hit || full)
                    begin
                        err_now = 1'b1;
                    end
                    else
                    begin
                        ctrl.push_all = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (hit)
                    begin
                        ctrl.pull_from_pos = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
                OP_TOUCH:
                begin
                    ctrl.push_to_pos = hit;
                end
                OP_LOOKUP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Last listed way after the update; 0 when empty
    always_comb
    begin
        lru_now = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((i + 1) == count_next)
            begin
                lru_now = lru_now | cell_after[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= hit;
            rank_reg  <= pos_ext[RANK_W-1:0];
            lru_reg   <= lru_now;
            error_reg <= err_now;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign rank        = rank_reg;
    assign lru_way     = lru_reg;
    assign entry_count = count_reg;
    assign error       = error_reg;

endmodule
